FILE: src/knd_pkg.sv
// Shared types and constants for the key notation decoder.
// Used by the front parser, the job queue, the result sequencer and the top level.
package knd_pkg;

    // Notation characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_UP_C  = 8'h43;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_OCT_0 = 8'h30;
    localparam logic [7:0] CH_OCT_7 = 8'h37;

    // Emitted byte values
    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] CTRL_MASK = 8'h1F;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] TAB_BYTE  = 8'h09;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
    localparam logic [7:0] CAP_RESET      = 8'hFF;

    // Result kinds
    localparam logic KIND_KEY = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    // Results per input character, queue depth
    localparam int MAX_RES     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One accepted character's worth of results: key bytes first, then summary
    typedef struct packed {
        logic [1:0]       n_keys;
        logic             has_sum;
        logic [7:0]       sum_len;
        logic [3:0][7:0]  keys;
    } t_job;

endpackage

FILE: src/knd_front.sv
// Front parser: classifies each notation character, tracks the escape state,
// applies the capacity limit and builds one queue job. Depends on knd_pkg.
module knd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_text_char,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_capacity,
    output logic          o_push,
    output knd_pkg::t_job o_job
);
    import knd_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_CARET, M_BSL, M_M1, M_M2, M_MB, M_MBC, M_MBCD, M_C1, M_C2, M_OCT
    } t_mode;

    t_mode           r_mode, n_mode;
    logic [8:0]      r_oct_val, n_oct_val;
    logic [1:0]      r_oct_dig, n_oct_dig;
    logic [7:0]      r_count, n_count;
    logic [7:0]      r_cap;

    logic [3:0][7:0] keys;
    logic [1:0]      nk;
    logic            fin;
    logic            do_idle;
    logic            is_oct;
    logic [8:0]      oct_next;
    logic [1:0]      dig_next;
    logic [7:0]      room;
    logic [1:0]      n_emit;
    logic [7:0]      c;

    assign c        = i_text_char;
    assign is_oct   = (c >= CH_OCT_0) && (c <= CH_OCT_7);
    assign oct_next = {r_oct_val[5:0], c[2:0]};
    assign dig_next = r_oct_dig + 2'd1;

    // Decode one character against the pending escape state
    always_comb begin
        n_mode    = M_IDLE;
        n_oct_val = r_oct_val;
        n_oct_dig = r_oct_dig;
        keys      = '0;
        nk        = 2'd0;
        fin       = 1'b0;
        do_idle   = 1'b0;
        case (r_mode)
            M_CARET: begin
                if (c == CH_NUL) begin
                    keys[0] = CH_CARET;
                    nk      = 2'd1;
                    fin     = 1'b1;
                end else begin
                    keys[0] = c & CTRL_MASK;
                    nk      = 2'd1;
                end
            end
            M_BSL: begin
                case (c)
                    CH_NUL:   fin = 1'b1;
                    CH_LO_E, CH_UP_E: begin
                        keys[0] = ESC_BYTE;
                        nk      = 2'd1;
                    end
                    CH_UP_M:  n_mode = M_M1;
                    CH_UP_C:  n_mode = M_C1;
                    CH_LO_N: begin
                        keys[0] = LF_BYTE;
                        nk      = 2'd1;
                    end
                    CH_LO_R: begin
                        keys[0] = CR_BYTE;
                        nk      = 2'd1;
                    end
                    CH_LO_T: begin
                        keys[0] = TAB_BYTE;
                        nk      = 2'd1;
                    end
                    default: begin
                        if (is_oct) begin
                            n_oct_val = {6'd0, c[2:0]};
                            n_oct_dig = 2'd1;
                            n_mode    = M_OCT;
                        end else begin
                            // backslash, '[' and any other character pass as literals
                            keys[0] = c;
                            nk      = 2'd1;
                        end
                    end
                endcase
            end
            M_M1: begin
                if (c == CH_DASH) begin
                    n_mode = M_M2;
                end else begin
                    keys[0] = CH_UP_M;
                    nk      = 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_M2: begin
                if (c == CH_NUL) begin
                    keys[0] = CH_UP_M;
                    keys[1] = CH_DASH;
                    nk      = 2'd2;
                    fin     = 1'b1;
                end else if (c == CH_BSL) begin
                    keys[0] = ESC_BYTE;
                    nk      = 2'd1;
                    n_mode  = M_MB;
                end else begin
                    keys[0] = ESC_BYTE;
                    keys[1] = c;
                    nk      = 2'd2;
                end
            end
            M_MB: begin
                if (c == CH_UP_C) begin
                    n_mode = M_MBC;
                end else begin
                    keys[0] = CH_BSL;
                    nk      = 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_MBC: begin
                if (c == CH_DASH) begin
                    n_mode = M_MBCD;
                end else begin
                    keys[0] = CH_BSL;
                    keys[1] = CH_UP_C;
                    nk      = 2'd2;
                    do_idle = 1'b1;
                end
            end
            M_MBCD: begin
                if (c == CH_NUL) begin
                    keys[0] = CH_BSL;
                    keys[1] = CH_UP_C;
                    keys[2] = CH_DASH;
                    nk      = 2'd3;
                    fin     = 1'b1;
                end else begin
                    keys[0] = c & CTRL_MASK;
                    nk      = 2'd1;
                end
            end
            M_C1: begin
                if (c == CH_DASH) begin
                    n_mode = M_C2;
                end else begin
                    keys[0] = CH_UP_C;
                    nk      = 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_C2: begin
                if (c == CH_NUL) begin
                    keys[0] = CH_UP_C;
                    keys[1] = CH_DASH;
                    nk      = 2'd2;
                    fin     = 1'b1;
                end else begin
                    keys[0] = c & CTRL_MASK;
                    nk      = 2'd1;
                end
            end
            M_OCT: begin
                if (is_oct) begin
                    if (dig_next >= OCT_MAX_DIGITS) begin
                        keys[0]   = oct_next[7:0];
                        nk        = 2'd1;
                        n_oct_val = '0;
                        n_oct_dig = '0;
                    end else begin
                        n_oct_val = oct_next;
                        n_oct_dig = dig_next;
                        n_mode    = M_OCT;
                    end
                end else begin
                    keys[0]   = r_oct_val[7:0];
                    nk        = 2'd1;
                    n_oct_val = '0;
                    n_oct_dig = '0;
                    do_idle   = 1'b1;
                end
            end
            default: do_idle = 1'b1;
        endcase

        // Decode the character from idle, in idle mode or after a failed lookahead
        if (do_idle) begin
            if (c == CH_NUL) begin
                fin = 1'b1;
            end else if (c == CH_CARET) begin
                n_mode = M_CARET;
            end else if (c == CH_BSL) begin
                n_mode = M_BSL;
            end else begin
                keys[nk] = c;
                nk       = nk + 2'd1;
            end
        end

        // End of string resets the octal accumulator
        if (fin) begin
            n_oct_val = '0;
            n_oct_dig = '0;
        end
    end

    // Limit key bytes to the room left under capacity
    assign room   = (r_count < r_cap) ? (r_cap - r_count) : 8'd0;
    assign n_emit = ({6'd0, nk} > room) ? room[1:0] : nk;
    assign n_count = fin ? 8'd0 : (r_count + {6'd0, n_emit});

    // Build the job; only jobs with at least one result are queued
    always_comb begin
        o_job         = '0;
        o_job.n_keys  = n_emit;
        o_job.has_sum = fin;
        o_job.sum_len = r_count + {6'd0, n_emit};
        o_job.keys    = keys;
    end
    assign o_push = i_accept && ((n_emit != 2'd0) || fin);

    // Hold parse state and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_oct_val <= '0;
            r_oct_dig <= '0;
            r_count   <= '0;
            r_cap     <= CAP_RESET;
        end else begin
            if (i_accept) begin
                r_mode    <= n_mode;
                r_oct_val <= n_oct_val;
                r_oct_dig <= n_oct_dig;
                r_count   <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_capacity;
            end
        end
    end

endmodule

FILE: src/knd_queue.sv
// Short job queue between the front parser and the result sequencer.
// Depends on knd_pkg for the job type and depth.
module knd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  knd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output knd_pkg::t_job o_head
);
    import knd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full       = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_head_valid))
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule

FILE: src/knd_back.sv
// Result sequencer: walks the head job into the output register one result per cycle
// unless the output stalls, and marks the last result of each character. Depends on knd_pkg.
module knd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  knd_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_kind,
    output logic [7:0]    o_key_byte,
    output logic [7:0]    o_seq_length,
    output logic          o_last_of_run
);
    import knd_pkg::*;

    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_key;
    logic [7:0] r_len;
    logic       r_last;
    logic [1:0] r_idx;

    logic       load;
    logic       is_key;
    logic       last;
    logic [2:0] total;

    assign total  = {1'b0, i_head.n_keys} + {2'b0, i_head.has_sum};
    assign is_key = (r_idx < i_head.n_keys);
    assign last   = (({1'b0, r_idx} + 3'd1) == total);
    assign load   = i_head_valid && (!r_valid || i_ready);
    assign o_pop  = load && last;

    // Load the next result when the output register is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : (r_idx + 2'd1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= is_key ? KIND_KEY : KIND_SUM;
            r_key  <= is_key ? i_head.keys[r_idx] : 8'd0;
            r_len  <= is_key ? 8'd0 : i_head.sum_len;
            r_last <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_key_byte    = r_key;
    assign o_seq_length  = r_len;
    assign o_last_of_run = r_last;

    a_mid_job_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> i_head_valid)
        else $error("job left the queue before all results were sent");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_valid)
        else $error("loaded result not presented");

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ({1'b0, r_idx} < total))
        else $error("result index beyond job length");

endmodule

FILE: src/key_notation_decoder.sv
// Top level of the key notation decoder: front parser, job queue, result sequencer.
// Depends on knd_pkg, knd_front, knd_queue and knd_back.
//
//  channel   | valid        | ready        | payload
//  ----------+--------------+--------------+---------------------------------------
//  input     | i_valid      | o_ready      | i_text_char
//  result    | o_valid      | i_ready      | o_kind o_key_byte o_seq_length o_last_of_run
//  config    | i_cfg_valid  | o_cfg_ready  | i_capacity
//
// One character is taken per cycle while the four-entry job queue has room.
// Each character yields zero to four results; the sequencer sends one per cycle while
// the output is not stalled, so a character's results hold the output side one after another.
// An accepted character's results are registered in the job queue and then in the output register.
// Synchronous active-low reset clears parse state, queue and output; capacity goes to 255.
// A stalled output fills the queue, after which o_ready drops.
module key_notation_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [7:0] o_key_byte,
    output logic [7:0] o_seq_length,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_capacity
);
    import knd_pkg::*;

    logic q_full;
    logic push;
    logic pop;
    logic head_valid;
    t_job job;
    t_job head;

    assign o_ready     = !q_full;
    assign o_cfg_ready = 1'b1;

    knd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_valid && o_ready),
        .i_text_char (i_text_char),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_capacity  (i_capacity),
        .o_push      (push),
        .o_job       (job)
    );

    knd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    knd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_key_byte    (o_key_byte),
        .o_seq_length  (o_seq_length),
        .o_last_of_run (o_last_of_run)
    );

endmodule
